[src/small_set_store_core_defines.svh]
// Assertion macros used by the set store core.
`ifndef SMALL_SET_STORE_CORE_DEFINES_SVH
`define SMALL_SET_STORE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("set store check failed");

// Next-cycle implication, disabled during reset.
`define SSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("set store check failed");

`endif

[src/sss_pkg.sv]
package sss_pkg;

  // Default number of entries
  localparam int CAPACITY_DEF = 64;

  localparam int MODE_W         = 2;
  localparam int VALUE_W        = 32;
  localparam int MEMBER_COUNT_W = 7;

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT
  } state_t;

  // Command word
  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // Response word
  typedef struct packed {
    logic                      success;
    logic [MEMBER_COUNT_W-1:0] member_count;
    logic                      full_refused;
  } rsp_t;

endpackage

[src/sss_mem.sv]
module sss_mem #(
  parameter int DEPTH = sss_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [$clog2(DEPTH)-1:0]             waddr,
  input  logic [sss_pkg::VALUE_W-1:0]          wdata,
  input  logic [$clog2(DEPTH)-1:0]             raddr,
  output logic [sss_pkg::VALUE_W-1:0]          rdata
);
  import sss_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/sss_ctrl.sv]
module sss_ctrl #(
  parameter int CAPACITY = sss_pkg::CAPACITY_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  sss_pkg::cmd_t                        cmd,
  output logic                                 done,
  output sss_pkg::rsp_t                        rsp,
  output logic [$clog2(CAPACITY+1)-1:0]        count,
  output logic                                 mem_we,
  output logic [$clog2(CAPACITY)-1:0]          mem_waddr,
  output logic [sss_pkg::VALUE_W-1:0]          mem_wdata,
  output logic [$clog2(CAPACITY)-1:0]          mem_raddr,
  input  logic [sss_pkg::VALUE_W-1:0]          mem_rdata
);
  import sss_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CX_W  = CNT_W + 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

  state_t               state, state_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [CNT_W-1:0]     count_next;
  logic                 found, found_next;
  logic [MODE_W-1:0]    mode_q, mode_next;
  logic [VALUE_W-1:0]   value_q, value_next;
  logic                 done_next;
  rsp_t                 rsp_next;
  logic [CX_W-1:0]      idx_p1, idx_p2, cnt_ext;
  logic                 hit;

  assign busy    = (state != ST_IDLE);
  assign idx_p1  = CX_W'(idx) + CX_W'(1);
  assign idx_p2  = CX_W'(idx) + CX_W'(2);
  assign cnt_ext = CX_W'(count);

  // Shared compare unit: one stored entry per cycle
  assign hit = (mem_rdata == value_q);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx     <= idx_next;
    found   <= found_next;
    mode_q  <= mode_next;
    value_q <= value_next;
    rsp     <= rsp_next;
  end

  // Sequencer: scan, decide, shift down on remove
  always_comb begin
    state_next = state;
    idx_next   = idx;
    count_next = count;
    found_next = found;
    mode_next  = mode_q;
    value_next = value_q;
    done_next  = 1'b0;
    rsp_next   = rsp;
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = mem_rdata;
    mem_raddr  = idx;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          mode_next  = cmd.mode;
          value_next = cmd.value;
          idx_next   = '0;
          found_next = 1'b0;
          mem_raddr  = '0;
          state_next = (count == '0) ? ST_DECIDE : ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (hit) begin
          found_next = 1'b1;
          state_next = ST_DECIDE;
        end else if (idx_p1 == cnt_ext) begin
          state_next = ST_DECIDE;
        end else begin
          idx_next  = IDX_W'(idx_p1);
          mem_raddr = IDX_W'(idx_p1);
        end
      end

      ST_DECIDE: begin
        done_next             = 1'b1;
        state_next            = ST_IDLE;
        rsp_next.success      = 1'b0;
        rsp_next.full_refused = 1'b0;
        unique case (mode_q)
          MODE_INSERT: begin
            if (!found) begin
              if (count == CNT_FULL) begin
                rsp_next.full_refused = 1'b1;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = IDX_W'(count);
                mem_wdata        = value_q;
                count_next       = count + CNT_W'(1);
                rsp_next.success = 1'b1;
              end
            end
          end
          MODE_REMOVE: begin
            if (found) begin
              rsp_next.success = 1'b1;
              if (idx_p1 < cnt_ext) begin
                // later entries move down one place
                mem_raddr  = IDX_W'(idx_p1);
                state_next = ST_SHIFT;
                done_next  = 1'b0;
              end else begin
                count_next = count - CNT_W'(1);
              end
            end
          end
          MODE_QUERY: begin
            rsp_next.success = found;
          end
          default: begin
          end
        endcase
        rsp_next.member_count = MEMBER_COUNT_W'(count_next);
      end

      ST_SHIFT: begin
        // rdata holds entry idx+1
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = mem_rdata;
        if (idx_p2 < cnt_ext) begin
          idx_next  = IDX_W'(idx_p1);
          mem_raddr = IDX_W'(idx_p2);
        end else begin
          count_next            = count - CNT_W'(1);
          done_next             = 1'b1;
          rsp_next.success      = 1'b1;
          rsp_next.full_refused = 1'b0;
          rsp_next.member_count = MEMBER_COUNT_W'(count_next);
          state_next            = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/small_set_store_core.sv]
// Set of distinct 32-bit values kept in insertion order, up to CAPACITY members.
// A word is taken when start is high and busy is low; its response appears on
// rsp for exactly one cycle with done high and cannot be held off. One shared
// comparator walks the stored entries one per cycle through a memory with one
// write port and one registered read port, from the first entry until the value
// matches or every member is read (no scan for an empty set). A decide step then
// writes an accepted insert and raises done; a remove first moves each later entry
// down one place. A new word may be started in the cycle done is high.
`include "small_set_store_core_defines.svh"

module small_set_store_core #(
  parameter int CAPACITY = sss_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  sss_pkg::cmd_t cmd,
  output logic          done,
  output sss_pkg::rsp_t rsp
);
  import sss_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [VALUE_W-1:0] mem_wdata, mem_rdata;
  logic [CNT_W-1:0]   count;

  // Sequencer and comparator
  sss_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .rsp       (rsp),
    .count     (count),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Entry storage
  sss_mem #(.DEPTH(CAPACITY)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Checks
  `SSS_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `SSS_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `SSS_ASSERT_NOW(a_count_cap, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `SSS_ASSERT_NOW(a_refuse_full, clk, rst, done && rsp.full_refused, !rsp.success && count == CNT_W'(CAPACITY))

endmodule

[tb/sv/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;

  localparam int SET_CAP = CAPACITY_DEF;
  // Mode 3 is not an operation; the store answers it with the current count
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;
  // 1700 words with long gaps fit well inside the run limit
  localparam int RUN_LIMIT = 1_500_000;
  localparam int SETTLE_CYCLES = 2 * SET_CAP + 40;
  localparam int MAX_PRINTED = 50;

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  small_set_store_core #(
    .CAPACITY(SET_CAP)
  ) u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .rsp  (rsp)
  );

  // Shadow copy of the set, in insertion order
  logic [VALUE_W-1:0] set_members[$];
  // Responses owed by the store, oldest first
  rsp_t owed_rsp[$];

  int words_sent = 0;
  int words_checked = 0;
  int refusals_seen = 0;
  int peak_members = 0;
  int error_count = 0;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one word to the shadow set and return the response it should give
  function automatic rsp_t apply_word(input cmd_t c);
    rsp_t r;
    int hit;
    r = '0;
    hit = -1;
    foreach (set_members[i]) begin
      if (hit < 0 && set_members[i] == c.value) hit = i;
    end
    case (c.mode)
      MODE_INSERT: begin
        if (hit < 0) begin
          if (set_members.size() >= SET_CAP) begin
            r.full_refused = 1'b1;
          end else begin
            set_members.push_back(c.value);
            r.success = 1'b1;
          end
        end
      end
      MODE_REMOVE: begin
        // later entries move down one place
        if (hit >= 0) begin
          set_members.delete(hit);
          r.success = 1'b1;
        end
      end
      MODE_QUERY: begin
        r.success = (hit >= 0);
      end
      default: begin
      end
    endcase
    r.member_count = MEMBER_COUNT_W'(set_members.size());
    if (set_members.size() > peak_members) peak_members = set_members.size();
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Members, a narrow band around zero for frequent hits, or any pattern
  function automatic logic [VALUE_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && set_members.size() > 0) begin
      return set_members[$urandom_range(0, set_members.size() - 1)];
    end
    if (r < 75) return VALUE_W'($urandom_range(0, 95)) - 32'd48;
    return $urandom();
  endfunction

  function automatic logic [VALUE_W-1:0] absent_value();
    logic [VALUE_W-1:0] v;
    int hits;
    do begin
      v = $urandom();
      hits = 0;
      foreach (set_members[i]) if (set_members[i] == v) hits++;
    end while (hits != 0);
    return v;
  endfunction

  function automatic logic [MODE_W-1:0] pick_mode(input int ins_pct, input int rem_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return MODE_INSERT;
    if (r < ins_pct + rem_pct) return MODE_REMOVE;
    if (r < 97) return MODE_QUERY;
    return MODE_NOP;
  endfunction

  // Offer one word; returns at the edge that takes it, start left high
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v);
    cmd_t c;
    int gap;
    c.mode = m;
    c.value = v;
    gap = gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    owed_rsp.push_back(apply_word(c));
    words_sent++;
  endtask

  // Hold off until every owed response is back
  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (owed_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("mismatch at response %0d: %s got %0h expected %0h",
               words_checked, what, got, want);
    end
  endtask

  // Compare one response with the oldest owed one
  task automatic check_response(input rsp_t got);
    rsp_t want;
    if (owed_rsp.size() == 0) begin
      report_mismatch("response with nothing owed", 32'(got), 32'd0);
    end else begin
      want = owed_rsp.pop_front();
      if (got.success !== want.success)
        report_mismatch("success", 32'(got.success), 32'(want.success));
      if (got.member_count !== want.member_count)
        report_mismatch("member_count", 32'(got.member_count), 32'(want.member_count));
      if (got.full_refused !== want.full_refused)
        report_mismatch("full_refused", 32'(got.full_refused), 32'(want.full_refused));
    end
    if (got.full_refused === 1'b1) refusals_seen++;
    words_checked++;
  endtask

  // Response monitor and run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("run limit of %0d cycles reached", RUN_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else if (!rst && done) begin
      check_response(rsp);
    end
  end

  // Field extremes, each operation and the corner cases on a small set
  task automatic test_directed();
    send_word(MODE_QUERY, 32'h0000_0000);   // lookup in empty set
    send_word(MODE_REMOVE, 32'h0000_0005);  // remove from empty set
    send_word(MODE_NOP, 32'h0000_0000);
    send_word(MODE_INSERT, 32'h8000_0000);
    send_word(MODE_INSERT, 32'h7FFF_FFFF);
    send_word(MODE_INSERT, 32'h0000_0000);
    send_word(MODE_INSERT, 32'hFFFF_FFFF);
    send_word(MODE_INSERT, 32'h7FFF_FFFF);  // already present
    send_word(MODE_QUERY, 32'h8000_0000);
    send_word(MODE_QUERY, 32'h7FFF_FFFF);
    send_word(MODE_QUERY, 32'h0000_0001);
    send_word(MODE_REMOVE, 32'h7FFF_FFFF);  // middle entry, later ones shift down
    send_word(MODE_QUERY, 32'hFFFF_FFFF);
    send_word(MODE_QUERY, 32'h7FFF_FFFF);
    send_word(MODE_REMOVE, 32'h7FFF_FFFF);  // now absent
    send_word(MODE_NOP, 32'hFFFF_FFFF);
    send_word(MODE_INSERT, 32'h5555_5555);
    send_word(MODE_INSERT, 32'hAAAA_AAAA);
    send_word(MODE_REMOVE, 32'h8000_0000);  // first entry
    send_word(MODE_REMOVE, 32'hAAAA_AAAA);  // last entry
    send_word(MODE_QUERY, 32'h0000_0000);
    wait_for_results();
  endtask

  // Fill to capacity, probe the full store, then empty it
  task automatic test_full_store();
    while (set_members.size() < SET_CAP) send_word(MODE_INSERT, $urandom());
    send_word(MODE_INSERT, set_members[SET_CAP - 1]);  // present while full
    send_word(MODE_INSERT, absent_value());            // refused
    send_word(MODE_QUERY, set_members[SET_CAP - 1]);
    send_word(MODE_QUERY, absent_value());
    send_word(MODE_NOP, $urandom());
    send_word(MODE_REMOVE, set_members[0]);
    send_word(MODE_REMOVE, set_members[set_members.size() - 1]);
    send_word(MODE_REMOVE, set_members[SET_CAP / 2]);
    while (set_members.size() < SET_CAP) send_word(MODE_INSERT, pick_value());
    send_word(MODE_INSERT, absent_value());
    // drain in random order with misses mixed in
    while (set_members.size() > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(MODE_REMOVE, absent_value());
      end else begin
        send_word(MODE_REMOVE, set_members[$urandom_range(0, set_members.size() - 1)]);
      end
    end
    wait_for_results();
  endtask

  // Random phases that push the set up, down and hold it level
  task automatic test_random(input int n_words);
    int ins_pct;
    int rem_pct;
    int phase;
    phase = 0;
    while (n_words > 0) begin
      case (phase % 3)
        0: begin ins_pct = 60; rem_pct = 15; end
        1: begin ins_pct = 15; rem_pct = 60; end
        default: begin ins_pct = 35; rem_pct = 35; end
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat (100) begin
        if (n_words > 0) begin
          send_word(pick_mode(ins_pct, rem_pct), pick_value());
          n_words--;
        end
      end
      if ($urandom_range(0, 2) == 0) wait_for_results();
      phase++;
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_store();
    test_random(1500);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d words over insert, remove, query and the unused code; set size 0 to %0d",
             words_sent, peak_members);
    $display("checked %0d responses, %0d refused inserts, %0d mismatches",
             words_checked, refusals_seen, error_count);
    if (error_count == 0 && owed_rsp.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
